// ----- rtl/core/hte_pkg.sv -----
package hte_pkg;

    localparam int COORD_W   = 24;
    localparam int COEF_W    = 48;
    localparam int NUM_COEF  = 8;
    localparam int CFG_IDX_W = 4;

    localparam int PP_N      = 6;
    localparam int PROD_W    = 72;
    localparam int T_W       = 74;
    localparam int NUM_W     = 84;
    localparam int DEN_W     = 75;
    localparam int DIV_W     = 102;
    localparam int Q_W       = 28;
    localparam int DIV_STEPS = 28;

    localparam int DIFF_W    = 30;
    localparam int SQ_IN_W   = 49;
    localparam int SQ_W      = 50;
    localparam int SQ_STEPS  = 25;
    localparam int ROOT_W    = 25;

    localparam logic [COORD_W-1:0] DIST_MAX = 24'hFFFFFF;

    // coefficient register indexes
    localparam logic [2:0] IDX_R0C0 = 3'd0;
    localparam logic [2:0] IDX_R0C1 = 3'd1;
    localparam logic [2:0] IDX_R0C2 = 3'd2;
    localparam logic [2:0] IDX_R1C0 = 3'd3;
    localparam logic [2:0] IDX_R1C1 = 3'd4;
    localparam logic [2:0] IDX_R1C2 = 3'd5;
    localparam logic [2:0] IDX_R2C0 = 3'd6;
    localparam logic [2:0] IDX_R2C1 = 3'd7;

    localparam logic [COEF_W-1:0] COEF_ONE = 48'h0001_0000_0000;

    localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
        COEF_ONE, '0, '0, '0, COEF_ONE, '0, '0, '0
    };

    // coefficient of each partial product; even ones multiply x, odd ones y
    localparam logic [2:0] PP_COEF [PP_N] = '{
        IDX_R0C0, IDX_R0C1, IDX_R1C0, IDX_R1C1, IDX_R2C0, IDX_R2C1
    };

    localparam logic signed [T_W-1:0] T3_ONE = T_W'(1) << 40;

    typedef struct packed {
        logic signed [COORD_W-1:0] dst_x;
        logic signed [COORD_W-1:0] dst_y;
        logic                      neg_u;
        logic                      neg_v;
        logic                      dz;
    } hte_div_side_t;

    typedef struct packed {
        logic dz;
        logic sat;
    } hte_sq_side_t;

endpackage

// ----- rtl/core/homography_transfer_error.sv -----
// Homography transfer error, one point correspondence per item.
// Input channel s_*: tdata carries src_x, src_y, dst_x, dst_y (signed Q16.8).
// Output channel m_*: tdata carries the distance (unsigned Q16.8), tuser the
// zero-denominator flag. One result item per input item, in order.
// Coefficients are written on cfg_we/cfg_index/cfg_data; indexes 8 and
// above are ignored. The user must write them only while no item is in
// flight; the block itself does not enforce this. An item passes registers
// of partial products, products, sums and magnitudes, 28 divider stages
// (clamp check plus 27 quotient bits), registers of difference, squares and
// sum, 25 square-root stages and the output register. One item per cycle
// unless m_tready stalls; both divider lanes and the root retire one bit per
// stage. Reset empties the pipeline and loads the identity homography.
// The whole pipeline advances together: when m_tvalid is high and m_tready is
// low, every stage holds and s_tready drops in the same cycle, so nothing is
// lost or repeated.
module homography_transfer_error (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [95:0]                     s_tdata,  // src_x, src_y, dst_x, dst_y
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // distance
    output logic                            m_tuser,  // denom_zero
    input  logic                            cfg_we,
    input  logic [hte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hte_pkg::COEF_W-1:0]      cfg_data
);
    import hte_pkg::*;

    logic                         en;
    logic [COEF_W-1:0]            coef_reg [NUM_COEF];

    logic signed [COORD_W-1:0]    src_x, src_y;

    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [48:0]           pp_lo_reg [PP_N];
    logic signed [47:0]           pp_hi_reg [PP_N];
    logic signed [PROD_W-1:0]     prod_reg  [PP_N];
    logic signed [T_W-1:0]        t_reg     [3];
    logic [T_W-1:0]               mag_reg   [3];
    logic signed [COORD_W-1:0]    dx_reg [4];
    logic signed [COORD_W-1:0]    dy_reg [4];
    logic                         neg_u_reg, neg_v_reg, dz_reg;

    logic [NUM_W-1:0]             num_u, num_v;
    logic [DEN_W-1:0]             den;
    hte_div_side_t                div_side_in, div_side_out;
    logic                         div_vld;
    logic [Q_W-1:0]               q_u, q_v;

    logic                         v5_reg, v6_reg, v7_reg;
    logic [COORD_W-1:0]           ex_reg, ey_reg;
    hte_sq_side_t                 side5_reg, side6_reg, side7_reg;
    logic [2*COORD_W-1:0]         sqx_reg, sqy_reg;
    logic [SQ_IN_W-1:0]           sum_reg;
    logic [DIFF_W-1:0]            ex_mag, ey_mag;
    logic                         sat_next;

    logic                         sq_vld;
    logic [ROOT_W-1:0]            root;
    logic [SQ_IN_W-1:0]           rem;
    hte_sq_side_t                 sq_side;
    logic [ROOT_W:0]              root_rnd;

    logic                         m_tvalid_reg;
    logic [COORD_W-1:0]           dist_reg;
    logic                         dz_out_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign src_x    = s_tdata[23:0];
    assign src_y    = s_tdata[47:24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= COEF_RESET[i];
        end
        else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_COEF))
        begin
            coef_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= div_vld;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // coefficient split in halves: unsigned low 24 bits, signed high 24 bits
    for (genvar j = 0; j < PP_N; j++)
    begin : g_pp
        logic [COEF_W-1:0]         c;
        logic signed [COORD_W-1:0] op;

        assign c  = coef_reg[PP_COEF[j]];
        assign op = (j % 2 == 0) ? src_x : src_y;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_lo_reg[j] <= $signed({1'b0, c[23:0]}) * op;
                pp_hi_reg[j] <= $signed(c[47:24]) * op;
                prod_reg[j]  <= $signed({pp_hi_reg[j], 24'b0}) + PROD_W'(pp_lo_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg[0] <= s_tdata[71:48];
            dy_reg[0] <= s_tdata[95:72];
            for (int i = 1; i < 4; i++)
            begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
            end

            t_reg[0] <= T_W'(prod_reg[0]) + T_W'(prod_reg[1])
                        + T_W'($signed({coef_reg[IDX_R0C2], 8'b0}));
            t_reg[1] <= T_W'(prod_reg[2]) + T_W'(prod_reg[3])
                        + T_W'($signed({coef_reg[IDX_R1C2], 8'b0}));
            t_reg[2] <= T_W'(prod_reg[4]) + T_W'(prod_reg[5]) + T3_ONE;

            for (int i = 0; i < 3; i++)
                mag_reg[i] <= t_reg[i][T_W-1] ? T_W'(-t_reg[i]) : T_W'(t_reg[i]);
            neg_u_reg <= t_reg[0][T_W-1] ^ t_reg[2][T_W-1];
            neg_v_reg <= t_reg[1][T_W-1] ^ t_reg[2][T_W-1];
            dz_reg    <= (t_reg[2] == '0);
        end
    end

    // round to nearest: (2|t|*2^8 + |d|) / (2|d|)
    assign num_u = NUM_W'({mag_reg[0], 9'b0}) + NUM_W'(mag_reg[2]);
    assign num_v = NUM_W'({mag_reg[1], 9'b0}) + NUM_W'(mag_reg[2]);
    assign den   = {mag_reg[2], 1'b0};

    assign div_side_in.dst_x = dx_reg[3];
    assign div_side_in.dst_y = dy_reg[3];
    assign div_side_in.neg_u = neg_u_reg;
    assign div_side_in.neg_v = neg_v_reg;
    assign div_side_in.dz    = dz_reg;

    hte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (v4_reg),
        .num_u    (num_u),
        .num_v    (num_v),
        .den      (den),
        .side_in  (div_side_in),
        .vld_out  (div_vld),
        .q_u      (q_u),
        .q_v      (q_v),
        .side_out (div_side_out)
    );

    always_comb
    begin
        logic signed [DIFF_W-1:0] u, v, ex, ey;
        u = DIFF_W'($signed({1'b0, q_u}));
        v = DIFF_W'($signed({1'b0, q_v}));
        if (div_side_out.neg_u)
            u = -u;
        if (div_side_out.neg_v)
            v = -v;
        ex = DIFF_W'(div_side_out.dst_x) - u;
        ey = DIFF_W'(div_side_out.dst_y) - v;
        ex_mag = ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
        ey_mag = ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
        sat_next = (|ex_mag[DIFF_W-1:COORD_W]) || (|ey_mag[DIFF_W-1:COORD_W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg        <= ex_mag[COORD_W-1:0];
            ey_reg        <= ey_mag[COORD_W-1:0];
            side5_reg.dz  <= div_side_out.dz;
            side5_reg.sat <= sat_next;

            sqx_reg   <= ex_reg * ex_reg;
            sqy_reg   <= ey_reg * ey_reg;
            side6_reg <= side5_reg;

            sum_reg   <= SQ_IN_W'(sqx_reg) + SQ_IN_W'(sqy_reg);
            side7_reg <= side6_reg;
        end
    end

    hte_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (v7_reg),
        .sq_in    (sum_reg),
        .side_in  (side7_reg),
        .vld_out  (sq_vld),
        .root     (root),
        .rem      (rem),
        .side_out (sq_side)
    );

    assign root_rnd = (rem > SQ_IN_W'(root)) ? (ROOT_W + 1)'(root) + 1'b1
                                             : (ROOT_W + 1)'(root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz_out_reg <= sq_side.dz;
            if (sq_side.dz || sq_side.sat || (|root_rnd[ROOT_W:COORD_W]))
                dist_reg <= DIST_MAX;
            else
                dist_reg <= root_rnd[COORD_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = dist_reg;
    assign m_tuser  = dz_out_reg;

endmodule

// ----- rtl/core/hte_div.sv -----
// Two-lane restoring divider, one quotient bit per stage, clamp check first.
module hte_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        vld_in,
    input  logic [hte_pkg::NUM_W-1:0]   num_u,
    input  logic [hte_pkg::NUM_W-1:0]   num_v,
    input  logic [hte_pkg::DEN_W-1:0]   den,
    input  hte_pkg::hte_div_side_t      side_in,
    output logic                        vld_out,
    output logic [hte_pkg::Q_W-1:0]     q_u,
    output logic [hte_pkg::Q_W-1:0]     q_v,
    output hte_pkg::hte_div_side_t      side_out
);
    import hte_pkg::*;

    logic [NUM_W-1:0]  num_in [2];
    logic [DIV_W-1:0]  rem_reg   [2][DIV_STEPS-1];
    logic [Q_W-2:0]    quo_reg   [2][DIV_STEPS];
    logic              clamp_reg [2][DIV_STEPS];
    logic [DEN_W-1:0]  den_reg   [DIV_STEPS-1];
    hte_div_side_t     side_reg  [DIV_STEPS];
    logic              vld_reg   [DIV_STEPS];

    assign num_in[0] = num_u;
    assign num_in[1] = num_v;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_stage
        logic [DEN_W-1:0] den_k;
        hte_div_side_t    side_k;
        logic             vld_k;

        if (k == 0)
        begin : g_first
            assign den_k  = den;
            assign side_k = side_in;
            assign vld_k  = vld_in;
        end
        else
        begin : g_next
            assign den_k  = den_reg[k-1];
            assign side_k = side_reg[k-1];
            assign vld_k  = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_k;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[k] <= side_k;
        end

        if (k < DIV_STEPS - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                    den_reg[k] <= den_k;
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DIV_W-1:0] rem_k;
            logic [DIV_W-1:0] trial;
            logic [DIV_W-1:0] rem_next;
            logic [Q_W-2:0]   quo_k;
            logic [Q_W-2:0]   quo_next;
            logic             clamp_k;
            logic             clamp_next;
            logic             ge;

            assign trial = DIV_W'(den_k) << (Q_W - 1 - k);
            assign ge    = !clamp_k && (rem_k >= trial);

            if (k == 0)
            begin : g_clamp
                assign rem_k      = DIV_W'(num_in[l]);
                assign quo_k      = '0;
                assign clamp_k    = 1'b0;
                assign clamp_next = ge;
                assign rem_next   = rem_k;
                assign quo_next   = quo_k;
            end
            else
            begin : g_bit
                assign rem_k      = rem_reg[l][k-1];
                assign quo_k      = quo_reg[l][k-1];
                assign clamp_k    = clamp_reg[l][k-1];
                assign clamp_next = clamp_k;
                assign rem_next   = ge ? rem_k - trial : rem_k;
                assign quo_next   = quo_k | ((Q_W-1)'(ge) << (Q_W - 1 - k));
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[l][k]   <= quo_next;
                    clamp_reg[l][k] <= clamp_next;
                end
            end

            if (k < DIV_STEPS - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                        rem_reg[l][k] <= rem_next;
                end
            end
        end
    end

    assign q_u = clamp_reg[0][DIV_STEPS-1] ? (Q_W'(1) << (Q_W - 1))
                                           : {1'b0, quo_reg[0][DIV_STEPS-1]};
    assign q_v = clamp_reg[1][DIV_STEPS-1] ? (Q_W'(1) << (Q_W - 1))
                                           : {1'b0, quo_reg[1][DIV_STEPS-1]};
    assign side_out = side_reg[DIV_STEPS-1];
    assign vld_out  = vld_reg[DIV_STEPS-1];

endmodule

// ----- rtl/core/hte_sqrt.sv -----
// Digit-by-digit integer square root, one result bit per stage.
module hte_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         vld_in,
    input  logic [hte_pkg::SQ_IN_W-1:0]  sq_in,
    input  hte_pkg::hte_sq_side_t        side_in,
    output logic                         vld_out,
    output logic [hte_pkg::ROOT_W-1:0]   root,
    output logic [hte_pkg::SQ_IN_W-1:0]  rem,
    output hte_pkg::hte_sq_side_t        side_out
);
    import hte_pkg::*;

    logic [SQ_W-1:0] v_reg    [SQ_STEPS];
    logic [SQ_W-1:0] r_reg    [SQ_STEPS];
    hte_sq_side_t    side_reg [SQ_STEPS];
    logic            vld_reg  [SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_stage
        logic [SQ_W-1:0] v_k;
        logic [SQ_W-1:0] r_k;
        logic [SQ_W-1:0] bit_k;
        logic [SQ_W-1:0] trial;
        hte_sq_side_t    side_k;
        logic            vld_k;
        logic            ge;

        if (i == 0)
        begin : g_first
            assign v_k    = SQ_W'(sq_in);
            assign r_k    = '0;
            assign side_k = side_in;
            assign vld_k  = vld_in;
        end
        else
        begin : g_next
            assign v_k    = v_reg[i-1];
            assign r_k    = r_reg[i-1];
            assign side_k = side_reg[i-1];
            assign vld_k  = vld_reg[i-1];
        end

        assign bit_k = SQ_W'(1) << (2 * (SQ_STEPS - 1 - i));
        assign trial = r_k + bit_k;
        assign ge    = v_k >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_k;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i]    <= ge ? v_k - trial : v_k;
                r_reg[i]    <= ge ? (r_k >> 1) + bit_k : r_k >> 1;
                side_reg[i] <= side_k;
            end
        end
    end

    // remainder stays below 2*root+1, root below 2^25
    assign root     = r_reg[SQ_STEPS-1][ROOT_W-1:0];
    assign rem      = v_reg[SQ_STEPS-1][SQ_IN_W-1:0];
    assign side_out = side_reg[SQ_STEPS-1];
    assign vld_out  = vld_reg[SQ_STEPS-1];

endmodule

// ----- test/tb.sv -----
`default_nettype none

module tb;
    import hte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [23:0] distance;
        logic        dz;
    } err_t;

    typedef struct {
        logic [95:0] data;   // {dst_y, dst_x, src_y, src_x}
        bit          known;
        logic [23:0] distance;
        logic        dz;
    } row_t;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 70;
    localparam logic [COEF_W-1:0] COEF_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 48'h8000_0000_0000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0] cfg_data = '0;

    logic signed [COEF_W-1:0] hcoef [NUM_COEF];
    err_t expect_q [$];
    row_t typed_q [$];
    int   errors, sent, checked, dz_seen, sat_seen, stall_cycles;
    int   burst_left;

    homography_transfer_error dut (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_we, .cfg_index, .cfg_data
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // round(t * 2^8 / d), ties away from zero, magnitude clamped at 2^27
    function automatic logic signed [63:0] round_div(input logic signed [127:0] t,
                                                     input logic signed [127:0] d);
        logic [127:0] nt, nd, num, den, q;
        logic neg;
        neg = t[127] ^ d[127];
        nt  = t[127] ? -t : t;
        nd  = d[127] ? -d : d;
        num = (nt << 9) + nd;
        den = nd << 1;
        if (num >= (den << 27))
            q = 128'd1 << 27;
        else
            q = num / den;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic void project(input logic [95:0] d, output logic signed [63:0] u,
                                    output logic signed [63:0] v, output logic dz);
        logic signed [127:0] x, y, t1, t2, t3;
        x  = $signed(d[23:0]);
        y  = $signed(d[47:24]);
        t1 = hcoef[0] * x + hcoef[1] * y + (128'(hcoef[2]) <<< 8);
        t2 = hcoef[3] * x + hcoef[4] * y + (128'(hcoef[5]) <<< 8);
        t3 = hcoef[6] * x + hcoef[7] * y + (128'sd1 <<< 40);
        dz = (t3 == 0);
        u  = dz ? 64'sd0 : round_div(t1, t3);
        v  = dz ? 64'sd0 : round_div(t2, t3);
    endfunction

    function automatic err_t transfer_error(input logic [95:0] d);
        logic signed [63:0] u, v, ex, ey;
        logic [63:0] s, r, rem, bit_w, mx, my;
        logic dz;
        err_t e;
        project(d, u, v, dz);
        e.dz = dz;
        e.distance = DIST_MAX;
        if (dz)
            return e;
        ex = $signed(d[71:48]) - u;
        ey = $signed(d[95:72]) - v;
        mx = ex < 0 ? -ex : ex;
        my = ey < 0 ? -ey : ey;
        if (mx >= (64'd1 << 24) || my >= (64'd1 << 24))
            return e;
        s = mx * mx + my * my;
        rem = s;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (rem >= r + bit_w)
            begin
                rem -= r + bit_w;
                r = (r >> 1) + bit_w;
            end
            else
                r >>= 1;
            bit_w >>= 2;
        end
        if (s - r * r > r)
            r++;
        e.distance = r > DIST_MAX ? DIST_MAX : r[23:0];
        return e;
    endfunction

    task automatic report(input string what, input logic [23:0] got_d, input logic got_z,
                          input logic [23:0] exp_d, input logic exp_z);
        errors++;
        $display("tb: mismatch %s: distance %h dz %b, expected distance %h dz %b",
                 what, got_d, got_z, exp_d, exp_z);
    endtask

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        row_t row;
        err_t e;
        if (s_tvalid && s_tready)
        begin
            row = typed_q.pop_front();
            e = transfer_error(row.data);
            if (row.known)
            begin
                e.distance = row.distance;
                e.dz = row.dz;
            end
            expect_q = {expect_q, e};
        end
        if (m_tvalid && m_tready)
        begin
            checked++;
            if (m_tuser)
                dz_seen++;
            if (m_tdata == DIST_MAX)
                sat_seen++;
            if (expect_q.size() == 0)
                report("unexpected item", m_tdata, m_tuser, '0, 1'b0);
            else
            begin
                e = expect_q.pop_front();
                if (m_tdata !== e.distance || m_tuser !== e.dz)
                    report("result", m_tdata, m_tuser, e.distance, e.dz);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            stall_cycles = 0;
        else if (++stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: watchdog expired with %0d results pending", expect_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // receiver back-pressure in one of four randomly redrawn patterns
    always @(posedge clk)
    begin
        int cyc;
        int mode;
        if (cyc % 50 == 0)
            mode = $urandom_range(0, 3);
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cyc % 4 == 0);
            default: m_tready <= (cyc % 32 >= 20);
        endcase
        cyc++;
    end

    task automatic send_item(input logic [95:0] d, input bit known = 0,
                             input logic [23:0] kd = '0, input logic kz = 1'b0);
        row_t row;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        row.data = d;
        row.known = known;
        row.distance = kd;
        row.dz = kz;
        typed_q = {typed_q, row};
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (expect_q.size() != 0);
    endtask

    // write all coefficients plus one out-of-range index that must be ignored
    task automatic load_coefs(input logic [COEF_W-1:0] c [NUM_COEF]);
        drain();
        for (int i = 0; i < NUM_COEF; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= c[i];
            @(posedge clk);
            hcoef[i] = c[i];
        end
        cfg_index <= CFG_IDX_W'($urandom_range(NUM_COEF, 15));
        cfg_data <= COEF_W'({$urandom, $urandom});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [95:0] rand_corr();
        logic [23:0] sx, sy, dx, dy;
        logic signed [63:0] u, v;
        logic dz;
        sx = rand_coord();
        sy = rand_coord();
        project({48'd0, sy, sx}, u, v, dz);
        if ($urandom_range(0, 4) == 0 || dz)
        begin
            dx = 24'($urandom);
            dy = 24'($urandom);
        end
        else
        begin
            // destination close to the projection: mostly unsaturated errors
            u += $signed($urandom_range(0, 8192)) - 4096;
            v += $signed($urandom_range(0, 8192)) - 4096;
            dx = (u > 64'sh7FFFFF) ? 24'h7FFFFF : (u < -64'sh800000) ? 24'h800000 : u[23:0];
            dy = (v > 64'sh7FFFFF) ? 24'h7FFFFF : (v < -64'sh800000) ? 24'h800000 : v[23:0];
        end
        return {dy, dx, sy, sx};
    endfunction

    function automatic logic [COEF_W-1:0] near(input logic [COEF_W-1:0] base, input int span);
        return base + COEF_W'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    initial
    begin
        static row_t dir [] = '{
            '{96'h0, 1, 24'h0, 1'b0},
            '{{24'h000100, 24'h000100, 24'h000100, 24'h000100}, 1, 24'h0, 1'b0},
            '{{24'h000400, 24'h000300, 24'h0, 24'h0}, 1, 24'h000500, 1'b0},
            '{{24'h0, 24'h7FFFFF, 24'h0, 24'h800000}, 1, DIST_MAX, 1'b0},
            '{{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF}, 1, DIST_MAX, 1'b0},
            '{{24'h800000, 24'h800000, 24'h800000, 24'h800000}, 1, 24'h0, 1'b0},
            '{{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 1, 24'h0, 1'b0},
            '{{24'h000001, 24'h000001, 24'h0, 24'h0}, 1, 24'h000001, 1'b0},
            '{{24'h000002, 24'h000001, 24'h0, 24'h0}, 1, 24'h000002, 1'b0},
            '{{24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF}, 0, 24'h0, 1'b0}
        };
        static row_t dz_rows [] = '{
            '{{24'h0, 24'h0, 24'h0, 24'h000100}, 1, DIST_MAX, 1'b1},
            '{{24'h7FFFFF, 24'h800000, 24'h800000, 24'h000100}, 1, DIST_MAX, 1'b1},
            '{{24'h000050, 24'h0, 24'h000050, 24'h0}, 1, 24'h0, 1'b0},
            '{{24'h0, 24'h0, 24'h0, 24'h000200}, 0, 24'h0, 1'b0},
            '{{24'h0, 24'h0, 24'h000030, 24'h000080}, 0, 24'h0, 1'b0},
            '{{24'h123456, 24'h7FFFFF, 24'h000777, 24'h0000FF}, 0, 24'h0, 1'b0}
        };
        logic [COEF_W-1:0] c [NUM_COEF];
        int kind;

        for (int i = 0; i < NUM_COEF; i++)
            hcoef[i] = COEF_RESET[i];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
            send_item(dir[i].data, dir[i].known, dir[i].distance, dir[i].dz);

        // perspective -1.0 on x: denominator vanishes at x = 1.0
        c = COEF_RESET;
        c[IDX_R2C0] = -COEF_ONE;
        load_coefs(c);
        foreach (dz_rows[i])
            send_item(dz_rows[i].data, dz_rows[i].known, dz_rows[i].distance, dz_rows[i].dz);

        c = '{default: COEF_MAX};
        load_coefs(c);
        repeat (4) send_item(rand_corr());
        c = '{default: COEF_MIN};
        load_coefs(c);
        repeat (4) send_item(rand_corr());

        for (int p = 0; p < 10; p++)
        begin
            kind = p % 4;
            for (int i = 0; i < NUM_COEF; i++)
            begin
                case (kind)
                    0: c[i] = near(COEF_RESET[i], 1 << 26);
                    1: c[i] = (i == IDX_R2C0 || i == IDX_R2C1) ? near('0, 1 << 12)
                             : (i == IDX_R0C2 || i == IDX_R1C2) ? near('0, 1 << 30)
                             : near(COEF_RESET[i], 1 << 30);
                    2: c[i] = COEF_W'({$urandom, $urandom});
                    default:
                        case ($urandom_range(0, 3))
                            0: c[i] = COEF_MAX;
                            1: c[i] = COEF_MIN;
                            2: c[i] = '0;
                            default: c[i] = COEF_ONE;
                        endcase
                endcase
            end
            if (kind == 1)
            begin
                c[IDX_R2C0] = '0;
                c[IDX_R2C1] = '0;
            end
            load_coefs(c);
            for (int n = 0; n < 150; n++)
            begin
                if (n == 75)
                    drain();
                send_item(rand_corr());
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expect_q.size() != 0)
            report("missing results", '0, 1'b0, expect_q[0].distance, expect_q[0].dz);
        $display("tb: %0d correspondences over 14 coefficient sets, %0d results checked",
                 sent, checked);
        $display("tb: %0d zero-denominator and %0d saturated results", dz_seen, sat_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
